// File: rtl/crp_pkg.sv
// ----------------------------------------------------------------------------
// crp_pkg
// Shared types and constants of the Catmull-Rom path follower.
// ----------------------------------------------------------------------------
package crp_pkg;

  localparam int MAX_POINTS_DEF = 16;
  localparam int MIN_POINTS     = 4;

  localparam int KIND_W     = 2;
  localparam int SEG_W      = 4;
  localparam int COORD_W    = 32;
  localparam int TIME_W     = 24;
  localparam int PCNT_W     = 5;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 24;

  localparam int LANES   = 3;
  localparam int CHUNK_W = 16;
  localparam int T2_W    = 32;
  localparam int T3_W    = 40;
  localparam int COEF_W  = 36;
  localparam int PROD_W  = COEF_W + CHUNK_W + 1;
  localparam int ACC_W   = 64;

  localparam int MUL_STEPS = 7;
  localparam int MSTEP_W   = $clog2(MUL_STEPS + 1);

  localparam logic [TIME_W-1:0] MAX_TIME_RST    = 24'h010000;
  localparam logic [PCNT_W-1:0] POINT_COUNT_RST = 5'd6;
  localparam logic [SEG_W-1:0]  SEGMENT_RST     = 4'd1;

  typedef enum logic [KIND_W-1:0] {
    KIND_LOAD   = 2'd0,
    KIND_STEP   = 2'd1,
    KIND_SETPOS = 2'd2
  } kind_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MAX_TIME    = 1'b0,
    REG_POINT_COUNT = 1'b1
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD0,
    ST_RD1,
    ST_RD2,
    ST_RD3,
    ST_COEF,
    ST_MUL,
    ST_EMIT
  } state_t;

  // how a partial product lines up with the Q16 term sum
  typedef enum logic [1:0] {
    SH_FLOOR16,
    SH_NONE,
    SH_UP16
  } shift_t;

  typedef struct packed {
    logic               load;
    logic               setpos;
    logic               step;
    logic               t2_en;
    logic               t3_en;
    logic [1:0]         rd_sel;
    logic               cap_en;
    logic [1:0]         cap_sel;
    logic               coef_en;
    logic               mul_en;
    logic [MSTEP_W-1:0] mul_step;
    logic               acc_en;
    logic               emit;
  } crp_cmd_t;

endpackage

// File: rtl/crp_ram.sv
// ----------------------------------------------------------------------------
// crp_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module crp_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// File: rtl/crp_ctrl.sv
// ----------------------------------------------------------------------------
// crp_ctrl
// Sequencer: decodes accepted words and walks the datapath through point
// reads, coefficient setup and the multiply-accumulate schedule.
// ----------------------------------------------------------------------------
module crp_ctrl import crp_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [KIND_W-1:0] in_kind,
  output logic              busy,
  output logic              out_valid,
  output crp_cmd_t          cmd
);

  state_t             state_r, state_nxt;
  logic [MSTEP_W-1:0] mstep_r, mstep_nxt;
  logic               out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      mstep_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      mstep_r     <= mstep_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    mstep_nxt     = mstep_r;
    out_valid_nxt = (state_r == ST_EMIT);
    cmd           = '0;
    cmd.mul_step  = mstep_r;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          case (in_kind)
            KIND_LOAD:   cmd.load = 1'b1;
            KIND_SETPOS: cmd.setpos = 1'b1;
            KIND_STEP: begin
              cmd.step  = 1'b1;
              state_nxt = ST_RD0;
            end
            default: ;
          endcase
        end
      end
      ST_RD0: begin
        cmd.rd_sel = 2'd0;
        cmd.t2_en  = 1'b1;
        state_nxt  = ST_RD1;
      end
      ST_RD1: begin
        cmd.rd_sel  = 2'd1;
        cmd.cap_en  = 1'b1;
        cmd.cap_sel = 2'd0;
        cmd.t3_en   = 1'b1;
        state_nxt   = ST_RD2;
      end
      ST_RD2: begin
        cmd.rd_sel  = 2'd2;
        cmd.cap_en  = 1'b1;
        cmd.cap_sel = 2'd1;
        state_nxt   = ST_RD3;
      end
      ST_RD3: begin
        cmd.rd_sel  = 2'd3;
        cmd.cap_en  = 1'b1;
        cmd.cap_sel = 2'd2;
        state_nxt   = ST_COEF;
      end
      ST_COEF: begin
        cmd.coef_en = 1'b1;
        mstep_nxt   = '0;
        state_nxt   = ST_MUL;
      end
      ST_MUL: begin
        // product of step k is added in the following step
        cmd.mul_en = (mstep_r < MSTEP_W'(MUL_STEPS));
        cmd.acc_en = (mstep_r != '0);
        mstep_nxt  = mstep_r + MSTEP_W'(1);
        if (mstep_r == MSTEP_W'(MUL_STEPS)) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        cmd.emit  = 1'b1;
        state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign busy      = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;

endmodule

// File: rtl/crp_dpath.sv
// ----------------------------------------------------------------------------
// crp_dpath
// Datapath: point tables, segment/time state, config registers and three
// axis lanes of coefficient setup and chunked multiply-accumulate.
// ----------------------------------------------------------------------------
module crp_dpath import crp_pkg::*; #(
  parameter int MAX_POINTS = MAX_POINTS_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  crp_cmd_t                  cmd,
  input  logic [SEG_W-1:0]          in_point_index,
  input  logic signed [COORD_W-1:0] in_coord_x,
  input  logic signed [COORD_W-1:0] in_coord_y,
  input  logic signed [COORD_W-1:0] in_coord_z,
  input  logic [TIME_W-1:0]         in_time_value,
  input  logic                      cfg_we,
  input  logic [CFG_IDX_W-1:0]      cfg_index,
  input  logic [CFG_DATA_W-1:0]     cfg_data,
  output logic signed [COORD_W-1:0] out_pos_x,
  output logic signed [COORD_W-1:0] out_pos_y,
  output logic signed [COORD_W-1:0] out_pos_z,
  output logic [SEG_W-1:0]          out_segment,
  output logic [TIME_W-1:0]         out_seg_time,
  output logic                      out_finished
);

  localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int CW = ($clog2(MAX_POINTS + 1) > PCNT_W) ? $clog2(MAX_POINTS + 1) : PCNT_W;
  localparam logic [CW-1:0] CNT_MIN = CW'(MIN_POINTS);
  localparam logic [CW-1:0] CNT_MAX = CW'(MAX_POINTS);

  // ---------------- config ----------------
  logic [TIME_W-1:0] max_time_r;
  logic [PCNT_W-1:0] pcount_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_time_r <= MAX_TIME_RST;
      pcount_r   <= POINT_COUNT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_MAX_TIME:    max_time_r <= cfg_data[TIME_W-1:0];
        REG_POINT_COUNT: pcount_r   <= cfg_data[PCNT_W-1:0];
        default: ;
      endcase
    end
  end

  logic [CW-1:0] pc_ext, cnt, last_seg, nseg, seg_ext;

  assign pc_ext   = CW'(pcount_r);
  assign cnt      = (pc_ext < CNT_MIN) ? CNT_MIN : ((pc_ext > CNT_MAX) ? CNT_MAX : pc_ext);
  assign last_seg = cnt - CW'(3);
  assign nseg     = cnt - CW'(2);

  // ---------------- segment / time state ----------------
  logic [SEG_W-1:0]  seg_r, seg_nxt;
  logic [TIME_W-1:0] time_r, time_nxt;
  logic              done_r, done_nxt;
  logic [TIME_W:0]   tsum, tdiff;

  assign seg_ext = CW'(seg_r);
  assign tsum    = {1'b0, time_r} + {1'b0, in_time_value};
  assign tdiff   = tsum - {1'b0, max_time_r};

  always_comb begin
    seg_nxt  = seg_r;
    time_nxt = time_r;
    done_nxt = done_r;
    if (cmd.setpos) begin
      seg_nxt  = in_point_index;
      time_nxt = in_time_value;
      done_nxt = 1'b0;
    end else if (cmd.step) begin
      if (tsum >= {1'b0, max_time_r}) begin
        if (seg_ext < last_seg) begin
          seg_nxt  = seg_r + SEG_W'(1);
          time_nxt = tdiff[TIME_W] ? '1 : tdiff[TIME_W-1:0];
        end else begin
          time_nxt = max_time_r;
          done_nxt = 1'b1;
        end
      end else begin
        time_nxt = tsum[TIME_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seg_r  <= SEGMENT_RST;
      time_r <= '0;
      done_r <= 1'b0;
    end else begin
      seg_r  <= seg_nxt;
      time_r <= time_nxt;
      done_r <= done_nxt;
    end
  end

  // ---------------- time powers ----------------
  logic [2*TIME_W-1:0]      tsq;
  logic [T2_W+TIME_W-1:0]   tcube;
  logic [T2_W-1:0]          t2_r;
  logic [T3_W-1:0]          t3_r;

  assign tsq   = (2*TIME_W)'(time_r) * (2*TIME_W)'(time_r);
  assign tcube = (T2_W+TIME_W)'(t2_r) * (T2_W+TIME_W)'(time_r);

  always_ff @(posedge clk) begin
    if (cmd.t2_en) begin
      t2_r <= tsq[2*TIME_W-1:CHUNK_W];
    end
    if (cmd.t3_en) begin
      t3_r <= tcube[T2_W+TIME_W-1:CHUNK_W];
    end
  end

  // ---------------- table addressing ----------------
  logic          direct;
  logic [CW-1:0] direct_addr, a0, a1, a2, a3, s_plus2, rd_full, widx;
  logic [AW-1:0] raddr, waddr;
  logic          we;

  // segment past the end or zero: output a stored point as is
  assign direct      = (seg_ext > nseg) || (seg_r == '0);
  assign direct_addr = (seg_ext > nseg) ? nseg : CW'(1);
  assign s_plus2     = seg_ext + CW'(2);
  assign a0          = seg_ext - CW'(1);
  assign a1          = seg_ext;
  assign a2          = seg_ext + CW'(1);
  assign a3          = (s_plus2 > cnt - CW'(1)) ? (cnt - CW'(1)) : s_plus2;

  always_comb begin
    case (cmd.rd_sel)
      2'd0:    rd_full = direct ? direct_addr : a0;
      2'd1:    rd_full = a1;
      2'd2:    rd_full = a2;
      default: rd_full = a3;
    endcase
  end

  assign raddr = rd_full[AW-1:0];
  assign widx  = CW'(in_point_index);
  assign waddr = widx[AW-1:0];
  assign we    = cmd.load && (widx < CNT_MAX);

  // ---------------- multiply schedule ----------------
  logic [CHUNK_W-1:0] chunk;
  logic [1:0]         csel;
  shift_t             sh_sel, sh_r;

  always_comb begin
    case (cmd.mul_step)
      3'd0: begin
        csel = 2'd0; chunk = time_r[CHUNK_W-1:0]; sh_sel = SH_FLOOR16;
      end
      3'd1: begin
        csel = 2'd0; chunk = CHUNK_W'(time_r[TIME_W-1:CHUNK_W]); sh_sel = SH_NONE;
      end
      3'd2: begin
        csel = 2'd1; chunk = t2_r[CHUNK_W-1:0]; sh_sel = SH_FLOOR16;
      end
      3'd3: begin
        csel = 2'd1; chunk = t2_r[2*CHUNK_W-1:CHUNK_W]; sh_sel = SH_NONE;
      end
      3'd4: begin
        csel = 2'd2; chunk = t3_r[CHUNK_W-1:0]; sh_sel = SH_FLOOR16;
      end
      3'd5: begin
        csel = 2'd2; chunk = t3_r[2*CHUNK_W-1:CHUNK_W]; sh_sel = SH_NONE;
      end
      default: begin
        csel = 2'd2; chunk = CHUNK_W'(t3_r[T3_W-1:2*CHUNK_W]); sh_sel = SH_UP16;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.mul_en) begin
      sh_r <= sh_sel;
    end
  end

  // ---------------- axis lanes ----------------
  logic signed [COORD_W-1:0] coord_in [LANES];
  logic signed [COORD_W-1:0] pos      [LANES];

  assign coord_in[0] = in_coord_x;
  assign coord_in[1] = in_coord_y;
  assign coord_in[2] = in_coord_z;

  for (genvar g = 0; g < LANES; g++) begin : g_lane
    logic [COORD_W-1:0]        rdata;
    logic signed [COORD_W-1:0] p0_r, p1_r, p2_r, pos_r;
    logic signed [COEF_W-1:0]  e0, e1, e2, e3;
    logic signed [COEF_W-1:0]  c1_r, c2_r, c3_r, coef;
    logic signed [PROD_W-1:0]  prod_r;
    logic signed [ACC_W-1:0]   acc_r, prod_ext, addend, half;
    logic [COORD_W-1:0]        sat;
    logic                      fits;

    crp_ram #(
      .WIDTH (COORD_W),
      .DEPTH (MAX_POINTS)
    ) u_ram (
      .clk   (clk),
      .we    (we),
      .waddr (waddr),
      .wdata (coord_in[g]),
      .raddr (raddr),
      .rdata (rdata)
    );

    assign e0 = {{(COEF_W-COORD_W){p0_r[COORD_W-1]}}, p0_r};
    assign e1 = {{(COEF_W-COORD_W){p1_r[COORD_W-1]}}, p1_r};
    assign e2 = {{(COEF_W-COORD_W){p2_r[COORD_W-1]}}, p2_r};
    assign e3 = {{(COEF_W-COORD_W){rdata[COORD_W-1]}}, rdata};

    always_comb begin
      case (csel)
        2'd0:    coef = c1_r;
        2'd1:    coef = c2_r;
        default: coef = c3_r;
      endcase
    end

    assign prod_ext = {{(ACC_W-PROD_W){prod_r[PROD_W-1]}}, prod_r};

    always_comb begin
      case (sh_r)
        SH_FLOOR16: addend = prod_ext >>> CHUNK_W;
        SH_NONE:    addend = prod_ext;
        default:    addend = prod_ext <<< CHUNK_W;
      endcase
    end

    assign half = acc_r >>> 1;
    assign fits = (&half[ACC_W-1:COORD_W-1]) || !(|half[ACC_W-1:COORD_W-1]);
    assign sat  = fits ? half[COORD_W-1:0]
                : (half[ACC_W-1] ? {1'b1, {(COORD_W-1){1'b0}}} : {1'b0, {(COORD_W-1){1'b1}}});

    always_ff @(posedge clk) begin
      if (cmd.cap_en) begin
        case (cmd.cap_sel)
          2'd0:    p0_r <= rdata;
          2'd1:    p1_r <= rdata;
          default: p2_r <= rdata;
        endcase
      end
      if (cmd.coef_en) begin
        // p3 comes straight off the read port
        c1_r  <= e2 - e0;
        c2_r  <= (e0 <<< 1) - ((e1 <<< 2) + e1) + (e2 <<< 2) - e3;
        c3_r  <= -e0 + ((e1 <<< 1) + e1) - ((e2 <<< 1) + e2) + e3;
        acc_r <= {{(ACC_W-COORD_W){p1_r[COORD_W-1]}}, p1_r} <<< 1;
      end else if (cmd.acc_en) begin
        acc_r <= acc_r + addend;
      end
      if (cmd.mul_en) begin
        prod_r <= coef * $signed({1'b0, chunk});
      end
      if (cmd.emit) begin
        pos_r <= direct ? p0_r : sat;
      end
    end

    assign pos[g] = pos_r;
  end

  assign out_pos_x    = pos[0];
  assign out_pos_y    = pos[1];
  assign out_pos_z    = pos[2];
  assign out_segment  = seg_r;
  assign out_seg_time = time_r;
  assign out_finished = done_r;

endmodule

// File: rtl/catmull_rom_path_follower_unit.sv
// ----------------------------------------------------------------------------
// catmull_rom_path_follower_unit
// Follows a 3-D path through a point table with uniform Catmull-Rom cubics.
// Load and set-position words take effect at the accept edge, one per cycle
// while not busy. A step word raises busy for 4 table reads on the single
// read port, coefficient setup, chunked multiply-accumulate and output;
// out_valid pulses in the first cycle with busy low; no word is taken while busy.
// Sync reset: segment 1, time 0, finished clear, max_time 1.0, 6 points.
// Point tables are not cleared by reset.
// ----------------------------------------------------------------------------
module catmull_rom_path_follower_unit import crp_pkg::*; #(
  parameter int MAX_POINTS = MAX_POINTS_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  output logic                      busy,
  input  logic [KIND_W-1:0]         in_kind,
  input  logic [SEG_W-1:0]          in_point_index,
  input  logic signed [COORD_W-1:0] in_coord_x,
  input  logic signed [COORD_W-1:0] in_coord_y,
  input  logic signed [COORD_W-1:0] in_coord_z,
  input  logic [TIME_W-1:0]         in_time_value,
  output logic                      out_valid,
  output logic signed [COORD_W-1:0] out_pos_x,
  output logic signed [COORD_W-1:0] out_pos_y,
  output logic signed [COORD_W-1:0] out_pos_z,
  output logic [SEG_W-1:0]          out_segment,
  output logic [TIME_W-1:0]         out_seg_time,
  output logic                      out_finished,
  input  logic                      cfg_we,
  input  logic [CFG_IDX_W-1:0]      cfg_index,
  input  logic [CFG_DATA_W-1:0]     cfg_data
);

  crp_cmd_t cmd;

  crp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .in_kind   (in_kind),
    .busy      (busy),
    .out_valid (out_valid),
    .cmd       (cmd)
  );

  crp_dpath #(
    .MAX_POINTS (MAX_POINTS)
  ) u_dpath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .in_point_index (in_point_index),
    .in_coord_x     (in_coord_x),
    .in_coord_y     (in_coord_y),
    .in_coord_z     (in_coord_z),
    .in_time_value  (in_time_value),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .out_pos_x      (out_pos_x),
    .out_pos_y      (out_pos_y),
    .out_pos_z      (out_pos_z),
    .out_segment    (out_segment),
    .out_seg_time   (out_seg_time),
    .out_finished   (out_finished)
  );

  // a step word always starts the sequencer
  a_step_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_kind == KIND_STEP) |=> busy)
    else $error("step word did not start the sequencer");

  // other words complete at the accept edge
  a_other_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_kind != KIND_STEP) |=> !busy)
    else $error("non-step word made the block busy");

  // a result word only follows a busy cycle
  a_out_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ($past(busy) && !busy))
    else $error("result word without a finished step");

  // result strobe is a single cycle
  a_out_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe longer than one cycle");

endmodule
